/* hw/rtl/vswa_pkg.sv */
// vswa_pkg: shared types and constants of the sample window averager.
// No dependencies; compile before every other file of the block.
package vswa_pkg;

    // Fixed field widths
    localparam int RAW_W = 16;
    localparam int AVG_W = 10;
    localparam int MINV_W = 3;

    // Reset contents
    localparam logic [AVG_W-1:0]  RESET_KELVIN    = 10'd300;
    localparam logic [MINV_W-1:0] MIN_VALID_RESET = 3'd2;

    // Error code window 0x8000..0x8FFF is the top nibble equal to 8
    localparam logic [3:0] ERR_NIBBLE = 4'h8;
    localparam int KELVIN_SHIFT = 6;

    // Action codes
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_POWERED = 2'd1,
        STATUS_TOO_FEW     = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_CHECK,
        S_DIVIDE,
        S_POST
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    store;
        logic    acc_start;
        logic    acc_step;
        logic    div_start;
        logic    div_step;
        logic    res_load;
        status_t res_code;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic acc_last;
        logic too_few;
        logic div_last;
        logic res_free;
    } stat_t;

endpackage

/* hw/rtl/vswa_if.sv */
// vswa_if: handshake channels of the sample window averager (item, result, config).
// Depends on vswa_pkg for field widths.
interface vswa_in_if
    import vswa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             action;
    logic [RAW_W-1:0] raw_reading;
    logic             chipset_on;

    modport source(output valid, action, raw_reading, chipset_on, input ready);
    modport sink(input valid, action, raw_reading, chipset_on, output ready);
endinterface

interface vswa_out_if
    import vswa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [AVG_W-1:0] average_temp;

    modport source(output valid, status, average_temp, input ready);
    modport sink(input valid, status, average_temp, output ready);
endinterface

interface vswa_cfg_if
    import vswa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MINV_W-1:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

/* hw/rtl/valid_sample_window_average.sv */
// Sample window averager top; depends on vswa_pkg, vswa_if, vswa_ctrl and vswa_dp.
// Store beat: taken in idle, no result. Powered-off read: the sequencer goes straight
// to posting with the not-powered status, then loads the result once the result slot
// is free. Powered read: the one-entry-a-cycle ring walk, the check against min_valid
// and the serial divider come before posting; one read at a time.
// Reset (rst_n, async low): every ring entry 300 K valid, write position 0, min_valid 2.
module valid_sample_window_average
    import vswa_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    vswa_in_if.sink       item,
    vswa_out_if.source    result,
    vswa_cfg_if.sink      cfg
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    vswa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Ring, accumulator and divider
    vswa_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .raw_reading (item.raw_reading),
        .cmd         (cmd),
        .stat        (stat),
        .result      (result),
        .cfg         (cfg)
    );

endmodule

/* hw/rtl/vswa_ctrl.sv */
// vswa_ctrl: sequencer of the sample window averager.
// Depends on vswa_pkg (state, command and status types) and vswa_if.
module vswa_ctrl
    import vswa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vswa_in_if.sink     item,
    input  stat_t       stat,
    output cmd_t        cmd
);

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    accept;

    assign accept = item.valid && item.ready;

    // State and pending status code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.action == ACT_READ)
                begin
                    if (!item.chipset_on)
                    begin
                        code_next  = STATUS_NOT_POWERED;
                        state_next = S_POST;
                    end
                    else
                    begin
                        state_next = S_ACCUM;
                    end
                end
            end
            S_ACCUM:
            begin
                if (stat.acc_last)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.too_few)
                begin
                    code_next  = STATUS_TOO_FEW;
                    state_next = S_POST;
                end
                else
                begin
                    code_next  = STATUS_OK;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (stat.div_last)
                    state_next = S_POST;
            end
            S_POST:
            begin
                if (stat.res_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        item.ready    = 1'b0;
        cmd.store     = 1'b0;
        cmd.acc_start = 1'b0;
        cmd.acc_step  = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.res_load  = 1'b0;
        cmd.res_code  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                item.ready    = 1'b1;
                cmd.store     = item.valid && item.action == ACT_STORE;
                cmd.acc_start = item.valid && item.action == ACT_READ && item.chipset_on;
            end
            S_ACCUM:
            begin
                cmd.acc_step = 1'b1;
            end
            S_CHECK:
            begin
                cmd.div_start = !stat.too_few;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            S_POST:
            begin
                cmd.res_load = stat.res_free;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A powered-off read goes straight to posting with the not-powered code
    a_off_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && accept && item.action == ACT_READ && !item.chipset_on)
        |=> (state_reg == S_POST && code_reg == STATUS_NOT_POWERED))
        else $error("powered-off read did not post not-powered status");

    // A store never leaves the idle state
    a_store_stay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && accept && item.action == ACT_STORE) |=> state_reg == S_IDLE)
        else $error("store beat left idle state");

    // The divider only runs for an ok result
    a_div_code: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIVIDE |-> code_reg == STATUS_OK)
        else $error("divider running for a non-ok result");
`endif

endmodule

/* hw/rtl/vswa_dp.sv */
// vswa_dp: sample ring, accumulator, serial divider, result and config registers.
// Depends on vswa_pkg (command/status types, constants) and vswa_if.
module vswa_dp
    import vswa_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RAW_W-1:0]  raw_reading,
    input  cmd_t              cmd,
    output stat_t             stat,
    vswa_out_if.source        result,
    vswa_cfg_if.sink          cfg
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = $clog2(WINDOW_DEPTH * 1023 + 1);
    localparam int STEP_W = $clog2(SUM_W);
    localparam int CMP_W  = (CNT_W > MINV_W) ? CNT_W : MINV_W;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic [AVG_W-1:0]  value_reg [WINDOW_DEPTH];
    logic              valid_reg [WINDOW_DEPTH];
    logic [IDX_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [IDX_W-1:0]  acc_idx_reg, acc_idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [MINV_W-1:0] min_valid_reg;
    logic              res_valid_reg;
    status_t           status_reg;
    logic [AVG_W-1:0]  avg_reg;

    logic              is_error;
    logic [AVG_W-1:0]  new_value;
    logic [CNT_W:0]    rem_shift;
    logic              q_bit;

    // Classify the incoming raw word
    assign is_error  = raw_reading[RAW_W-1 -: 4] == ERR_NIBBLE;
    assign new_value = is_error ? '0 : raw_reading[KELVIN_SHIFT +: AVG_W];

    // Sample ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                value_reg[i] <= RESET_KELVIN;
                valid_reg[i] <= 1'b1;
            end
            wr_pos_reg <= '0;
        end
        else if (cmd.store)
        begin
            value_reg[wr_pos_reg] <= new_value;
            valid_reg[wr_pos_reg] <= !is_error;
            wr_pos_reg            <= wr_pos_next;
        end
    end

    assign wr_pos_next = (wr_pos_reg == LAST_IDX) ? '0 : wr_pos_reg + 1'b1;

    // Walk the ring, one entry a cycle
    always_comb
    begin
        acc_idx_next = acc_idx_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        if (cmd.acc_start)
        begin
            acc_idx_next = '0;
            sum_next     = '0;
            count_next   = '0;
        end
        else if (cmd.acc_step)
        begin
            acc_idx_next = acc_idx_reg + 1'b1;
            if (valid_reg[acc_idx_reg])
            begin
                sum_next   = sum_reg + SUM_W'(value_reg[acc_idx_reg]);
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Restoring divider, one quotient bit a cycle
    assign rem_shift = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
    assign q_bit     = rem_shift >= {1'b0, count_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (cmd.div_start)
        begin
            dvd_next  = sum_reg;
            rem_next  = '0;
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            dvd_next  = {dvd_reg[SUM_W-2:0], q_bit};
            rem_next  = q_bit ? rem_shift - {1'b0, count_reg} : rem_shift;
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_idx_reg <= acc_idx_next;
        sum_reg     <= sum_next;
        count_reg   <= count_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
    end

    // Config register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_valid_reg <= MIN_VALID_RESET;
        else if (cfg.valid)
            min_valid_reg <= cfg.data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.res_load)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_code;
            avg_reg    <= (cmd.res_code == STATUS_OK) ? dvd_reg[AVG_W-1:0] : '0;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.status       = status_reg;
    assign result.average_temp = avg_reg;

    // Status to controller
    assign stat.acc_last = acc_idx_reg == LAST_IDX;
    assign stat.too_few  = (count_reg == '0) ||
                           (CMP_W'(count_reg) < CMP_W'(min_valid_reg));
    assign stat.div_last = step_reg == LAST_STEP;
    assign stat.res_free = !res_valid_reg || result.ready;

`ifndef NO_ASSERTIONS
    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!res_valid_reg || result.ready))
        else $error("result overwritten before it was taken");

    // Error-status results carry a zero average
    a_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg != STATUS_OK) |-> avg_reg == '0)
        else $error("non-ok result with nonzero average");

    // Divider never starts with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> count_reg != '0)
        else $error("divide by zero count");

    // Ring pointer stays inside the window
    a_wr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pos_reg <= LAST_IDX)
        else $error("write position out of range");
`endif

endmodule

/* tb/valid_sample_window_average_tb.sv */
// Testbench of valid_sample_window_average: directed table, then random beats.
// A local window model predicts every untyped read. Depends on vswa_pkg, vswa_if and the block.
module valid_sample_window_average_tb
    import vswa_pkg::*;
();

    localparam int DEPTH         = 4;
    localparam int SETTLE_CYCLES = 25;      // margin for a powered read to finish
    localparam int LONG_STALL    = 300;
    localparam int SEG_ITEMS     = 140;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        status_t          status;
        logic [AVG_W-1:0] avg;
    } reading_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              action;
        logic [RAW_W-1:0]  raw;
        logic              powered;
        logic              typed;
        status_t           status;
        logic [AVG_W-1:0]  avg;
        logic [MINV_W-1:0] level;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    vswa_in_if  item_ch();
    vswa_out_if res_ch();
    vswa_cfg_if cfg_ch();

    valid_sample_window_average #(.WINDOW_DEPTH(DEPTH)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Window model state
    logic [AVG_W-1:0]  ring_kelvin [DEPTH];
    logic              ring_ok     [DEPTH];
    int unsigned       ring_pos;
    logic [MINV_W-1:0] min_valid_model;

    reading_t    expected_readings[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // Idle rates, long stall request
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          want_long_stall = 1'b0;
    bit          long_stall_done = 1'b0;
    int unsigned stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Store beat: error codes go in as invalid entries
    function automatic void record_sample(input logic [RAW_W-1:0] raw);
        if (raw[RAW_W-1 -: 4] == ERR_NIBBLE)
        begin
            ring_ok[ring_pos]     = 1'b0;
            ring_kelvin[ring_pos] = '0;
        end
        else
        begin
            ring_ok[ring_pos]     = 1'b1;
            ring_kelvin[ring_pos] = AVG_W'(raw >> KELVIN_SHIFT);
        end
        ring_pos = (ring_pos + 1) % DEPTH;
    endfunction

    // Read beat: power first, then the valid count, then the truncated mean
    function automatic reading_t window_reading(input logic powered);
        reading_t    r;
        int unsigned count;
        int unsigned sum;
        count = 0;
        sum   = 0;
        if (!powered)
        begin
            r.status = STATUS_NOT_POWERED;
            r.avg    = '0;
            return r;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ring_ok[i])
            begin
                count++;
                sum += ring_kelvin[i];
            end
        end
        if (count == 0 || count < min_valid_model)
        begin
            r.status = STATUS_TOO_FEW;
            r.avg    = '0;
        end
        else
        begin
            r.status = STATUS_OK;
            r.avg    = AVG_W'(sum / count);
        end
        return r;
    endfunction

    // Offer one beat after random gaps; predict at the accepting edge
    task automatic send_item(input logic act, input logic [RAW_W-1:0] raw,
                             input logic powered, input logic typed,
                             input status_t t_status, input logic [AVG_W-1:0] t_avg);
        bit       taken;
        reading_t typed_reading;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.action      <= act;
        item_ch.raw_reading <= raw;
        item_ch.chipset_on  <= powered;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = (item_ch.ready === 1'b1);
        end
        if (act == ACT_STORE)
            record_sample(raw);
        else if (typed)
        begin
            typed_reading.status = t_status;
            typed_reading.avg    = t_avg;
            expected_readings.push_back(typed_reading);
        end
        else
            expected_readings.push_back(window_reading(powered));
    endtask

    // Register write only once the block has drained
    task automatic write_min_valid(input logic [MINV_W-1:0] level);
        bit taken;
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= level;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = (cfg_ch.ready === 1'b1);
        end
        min_valid_model = level;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly full-range words, a share of error codes and of edge values
    function automatic logic [RAW_W-1:0] pick_raw(input int unsigned err_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < err_pct)
            return {ERR_NIBBLE, 12'($urandom)};
        if (roll < err_pct + 8)
        begin
            case ($urandom_range(5))
                0: return 16'h0000;
                1: return 16'hFFFF;
                2: return 16'h7FFF;
                3: return 16'h9000;
                4: return 16'h003F;
                default: return 16'hFFC0;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Result ready, with one long hold-off on request
    always @(negedge clk)
    begin
        if (want_long_stall && !long_stall_done)
        begin
            long_stall_done = 1'b1;
            stall_left      = LONG_STALL;
        end
        if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("result beat with none expected: status %0d average_temp %0d",
                       res_ch.status, res_ch.average_temp);
                fail_count++;
            end
            else
            begin
                if (res_ch.status !== expected_readings[0].status)
                begin
                    $error("status: expected %0d, actual %0d",
                           expected_readings[0].status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.average_temp !== expected_readings[0].avg)
                begin
                    $error("average_temp: expected %0d, actual %0d",
                           expected_readings[0].avg, res_ch.average_temp);
                    fail_count++;
                end
                void'(expected_readings.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL valid_sample_window_average");
            $finish;
        end
    end

    initial
    begin
        plan_row_t         plan[$];
        logic [MINV_W-1:0] seg_level [6];
        int unsigned       seg_err   [6];
        logic              act;

        seg_level = '{3'd1, 3'd3, 3'd5, 3'd2, 3'd6, 3'd4};
        seg_err   = '{20, 60, 10, 85, 40, 30};

        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.action      = ACT_STORE;
        item_ch.raw_reading = '0;
        item_ch.chipset_on  = 1'b0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;

        for (int i = 0; i < DEPTH; i++)
        begin
            ring_kelvin[i] = RESET_KELVIN;
            ring_ok[i]     = 1'b1;
        end
        ring_pos        = 0;
        min_valid_model = MIN_VALID_RESET;

        // Directed table; typed rows carry their own expected reading
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b1, 1'b1, STATUS_OK, 10'd300, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b0, 1'b1, STATUS_NOT_POWERED, 10'd0,
                         3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'hFFFF, 1'b0, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'hFFFF, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'hFFFF, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'hFFFF, 1'b0, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b1, 1'b1, STATUS_OK, 10'd1023, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h0000, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h0040, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h7FFF, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'hFFC0, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'hFFFF, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        // error window edges 8000 and 8FFF go in as invalid entries, 9000 as valid
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h8000, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h8FFF, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h9000, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h8ABC, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        // one valid entry against min_valid 2, then power off wins over the count
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b1, 1'b1, STATUS_TOO_FEW, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b0, 1'b1, STATUS_NOT_POWERED, 10'd0,
                         3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h8123, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h8FFF, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h8456, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b1, 1'b1, STATUS_TOO_FEW, 10'd0, 3'd0});
        // min_valid 0 still needs one valid entry
        plan.push_back('{ROW_CFG,  ACT_STORE, 16'h0000, 1'b0, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b1, 1'b1, STATUS_TOO_FEW, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_STORE, 16'h4B00, 1'b1, 1'b0, STATUS_OK, 10'd0, 3'd0});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b1, 1'b1, STATUS_OK, 10'd300, 3'd0});
        // min_valid beyond the window depth never passes
        plan.push_back('{ROW_CFG,  ACT_STORE, 16'h0000, 1'b0, 1'b0, STATUS_OK, 10'd0, 3'd7});
        plan.push_back('{ROW_ITEM, ACT_READ,  16'h0000, 1'b1, 1'b1, STATUS_TOO_FEW, 10'd0, 3'd0});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_min_valid(plan[i].level);
            else
                send_item(plan[i].action, plan[i].raw, plan[i].powered, plan[i].typed,
                          plan[i].status, plan[i].avg);
        end

        // Random segments: receiver idles, then sender idles, then neither
        for (int seg = 0; seg < 6; seg++)
        begin
            send_idle_pct = (seg < 2) ? 13 : (seg < 4) ? 56 : 0;
            recv_idle_pct = (seg < 2) ? 56 : (seg < 4) ? 13 : 0;
            write_min_valid(seg_level[seg]);
            if (seg == 4)
                want_long_stall = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                act = ($urandom_range(99) < 35) ? ACT_READ : ACT_STORE;
                send_item(act, pick_raw(seg_err[seg]), ($urandom_range(99) < 85), 1'b0,
                          STATUS_OK, '0);
            end
        end

        // Drain
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS valid_sample_window_average");
        else
            $display("FAIL valid_sample_window_average");
        $finish;
    end

endmodule
